// ===== src/mrpb_pkg.sv =====
`default_nettype none

package mrpb_pkg;

    // widths of the fields on the ports
    localparam int GRID_FIELD_BITS = 10;
    localparam int POS_FIELD_BITS  = 31;

    // op codes of an input beat
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_GRID   = 2'd1;
    localparam logic [1:0] OP_TOKEN  = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // sticky error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_EMPTY    = 3'd1;
    localparam logic [2:0] ERR_NO_GRID  = 3'd2;
    localparam logic [2:0] ERR_MISMATCH = 3'd3;
    localparam logic [2:0] ERR_UNUSED   = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW = 3'd5;

    typedef enum logic [2:0] {
        KIND_BEGIN,
        KIND_GRID,
        KIND_TEXT,
        KIND_IMAGE,
        KIND_FINISH
    } item_kind_t;

    // decoded control of one queued item
    typedef struct packed {
        item_kind_t kind;
        logic       start_over;   // begin: start beyond the position range
        logic       grid_empty;   // grid: zero rows or zero columns
    } item_ctrl_t;

endpackage

`default_nettype wire

// ===== src/mrpb_ram.sv =====
`default_nettype none

module mrpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/mrpb_front.sv =====
`default_nettype none

module mrpb_front
    import mrpb_pkg::*;
#(
    parameter int SIDE_W = 10,
    parameter int POS_W  = 31,
    localparam int ENTRY_W = 4 * SIDE_W
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 op,
    input  wire logic [POS_FIELD_BITS-1:0]  start_position,
    input  wire logic [GRID_FIELD_BITS-1:0] grid_rows,
    input  wire logic [GRID_FIELD_BITS-1:0] grid_cols,
    input  wire logic                       image_token,
    output logic                            q_valid,
    input  wire logic                       q_pop,
    output item_ctrl_t                      q_ctrl,
    output logic      [POS_W-1:0]           q_start,
    output logic      [ENTRY_W-1:0]         q_entry
);

    item_ctrl_t             dec_ctrl;
    logic [SIDE_W-1:0]      rows_m;
    logic [SIDE_W-1:0]      cols_m;
    logic [SIDE_W-1:0]      side_max;
    logic [2*SIDE_W-1:0]    area;

    item_ctrl_t             ctrl_q_reg  [2];
    logic [POS_W-1:0]       start_q_reg [2];
    logic [ENTRY_W-1:0]     entry_q_reg [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;
    logic                   push;

    // classify the beat
    always_comb
    begin
        rows_m   = grid_rows[SIDE_W-1:0];
        cols_m   = grid_cols[SIDE_W-1:0];
        side_max = (rows_m > cols_m) ? rows_m : cols_m;
        area     = (2*SIDE_W)'(rows_m) * (2*SIDE_W)'(cols_m);

        dec_ctrl.start_over = (start_position >> POS_W) != '0;
        dec_ctrl.grid_empty = (rows_m == '0) || (cols_m == '0);
        case (op)
            OP_BEGIN:  dec_ctrl.kind = KIND_BEGIN;
            OP_GRID:   dec_ctrl.kind = KIND_GRID;
            OP_TOKEN:  dec_ctrl.kind = image_token ? KIND_IMAGE : KIND_TEXT;
            OP_FINISH: dec_ctrl.kind = KIND_FINISH;
            default:   dec_ctrl.kind = KIND_FINISH;
        endcase
    end

    // two-deep queue
    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_ctrl   = ctrl_q_reg[rd_ptr_reg];
    assign q_start  = start_q_reg[rd_ptr_reg];
    assign q_entry  = entry_q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_q_reg[wr_ptr_reg]  <= dec_ctrl;
            start_q_reg[wr_ptr_reg] <= start_position[POS_W-1:0];
            entry_q_reg[wr_ptr_reg] <= {area, side_max, cols_m};
        end
    end

endmodule

`default_nettype wire

// ===== src/mrpb_back.sv =====
`default_nettype none

module mrpb_back
    import mrpb_pkg::*;
#(
    parameter int MAX_GRIDS = 16,
    parameter int SIDE_W    = 10,
    parameter int POS_W     = 31,
    localparam int ENTRY_W  = 4 * SIDE_W,
    localparam int CNT_W    = $clog2(MAX_GRIDS + 1),
    localparam int ADDR_W   = (MAX_GRIDS > 1) ? $clog2(MAX_GRIDS) : 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    output logic                           q_pop,
    input  wire item_ctrl_t                q_ctrl,
    input  wire logic [POS_W-1:0]          q_start,
    input  wire logic [ENTRY_W-1:0]        q_entry,
    output logic                           ram_wr_en,
    output logic      [ADDR_W-1:0]         ram_wr_addr,
    output logic      [ENTRY_W-1:0]        ram_wr_data,
    output logic      [ADDR_W-1:0]         ram_rd_addr,
    input  wire logic [ENTRY_W-1:0]        ram_rd_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           position_valid,
    output logic      [POS_FIELD_BITS-1:0] time_position,
    output logic      [POS_FIELD_BITS-1:0] height_position,
    output logic      [POS_FIELD_BITS-1:0] width_position,
    output logic      [2:0]                error_code,
    output logic      [POS_FIELD_BITS-1:0] next_position
);

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // prompt state
    logic [POS_W-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0]    loaded_reg, loaded_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                in_run_reg, in_run_next;
    logic [SIDE_W-1:0]   row_reg, row_next;
    logic [SIDE_W-1:0]   col_reg, col_next;
    logic [2*SIDE_W-1:0] len_reg, len_next;
    logic [2:0]          err_reg, err_next;

    // head grid read-back with write forwarding
    logic                fwd_hit_reg;
    logic [ENTRY_W-1:0]  fwd_data_reg;
    logic [ENTRY_W-1:0]  head;
    logic [SIDE_W-1:0]   head_cols;
    logic [SIDE_W-1:0]   head_max;
    logic [2*SIDE_W-1:0] head_area;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic                posv_reg;
    logic [POS_W-1:0]    tp_reg, hp_reg, wp_reg, np_reg;
    logic [2:0]          eo_reg;

    logic                fire;
    logic                tok_valid;
    logic [POS_W-1:0]    tp, hp, wp;
    logic [POS_W:0]      adv_sum;
    logic                close_fail;
    logic [POS_W-1:0]    closed_cur;
    logic [CNT_W-1:0]    closed_idx;
    logic                run_ok;
    logic [SIDE_W-1:0]   row_eff, col_eff;
    logic [2*SIDE_W-1:0] len_eff;

    assign fire  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = fire;

    assign head      = fwd_hit_reg ? fwd_data_reg : ram_rd_data;
    assign head_cols = head[SIDE_W-1:0];
    assign head_max  = head[2*SIDE_W-1:SIDE_W];
    assign head_area = head[ENTRY_W-1:2*SIDE_W];

    assign ram_wr_addr = loaded_reg[ADDR_W-1:0];
    assign ram_wr_data = q_entry;
    assign ram_rd_addr = idx_next[ADDR_W-1:0];

    assign adv_sum    = {1'b0, cur_reg} + (POS_W+1)'(head_max);
    assign close_fail = in_run_reg && (len_reg != head_area);
    assign closed_cur = in_run_reg ? adv_sum[POS_W-1:0] : cur_reg;
    assign closed_idx = in_run_reg ? idx_reg + CNT_W'(1) : idx_reg;

    always_comb
    begin
        cur_next    = cur_reg;
        loaded_next = loaded_reg;
        idx_next    = idx_reg;
        in_run_next = in_run_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        len_next    = len_reg;
        err_next    = err_reg;
        ram_wr_en   = 1'b0;
        tok_valid   = 1'b0;
        tp          = '0;
        hp          = '0;
        wp          = '0;
        run_ok      = 1'b0;
        row_eff     = row_reg;
        col_eff     = col_reg;
        len_eff     = len_reg;

        if (fire)
        begin
            case (q_ctrl.kind)
                KIND_BEGIN:
                begin
                    cur_next    = q_ctrl.start_over ? '0 : q_start;
                    loaded_next = '0;
                    idx_next    = '0;
                    in_run_next = 1'b0;
                    row_next    = '0;
                    col_next    = '0;
                    len_next    = '0;
                    err_next    = q_ctrl.start_over ? ERR_OVERFLOW : ERR_NONE;
                end
                KIND_GRID:
                begin
                    if (err_reg == ERR_NONE)
                    begin
                        if (q_ctrl.grid_empty)
                        begin
                            err_next = ERR_EMPTY;
                        end
                        else if (loaded_reg == CNT_W'(MAX_GRIDS))
                        begin
                            err_next = ERR_OVERFLOW;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            loaded_next = loaded_reg + CNT_W'(1);
                        end
                    end
                end
                KIND_TEXT:
                begin
                    if (err_reg == ERR_NONE)
                    begin
                        in_run_next = 1'b0;
                        if (close_fail)
                        begin
                            err_next = ERR_MISMATCH;
                        end
                        else
                        begin
                            idx_next = closed_idx;
                            row_next = '0;
                            col_next = '0;
                            len_next = '0;
                            if (closed_cur == POS_MAX)
                            begin
                                cur_next = closed_cur;
                                err_next = ERR_OVERFLOW;
                            end
                            else
                            begin
                                tok_valid = 1'b1;
                                tp        = closed_cur;
                                hp        = closed_cur;
                                wp        = closed_cur;
                                cur_next  = closed_cur + POS_W'(1);
                            end
                        end
                    end
                end
                KIND_IMAGE:
                begin
                    if (err_reg == ERR_NONE)
                    begin
                        if (in_run_reg)
                        begin
                            run_ok = 1'b1;
                        end
                        else if (idx_reg >= loaded_reg)
                        begin
                            err_next = ERR_NO_GRID;
                        end
                        else if (adv_sum[POS_W])
                        begin
                            err_next = ERR_OVERFLOW;
                        end
                        else
                        begin
                            run_ok  = 1'b1;
                            row_eff = '0;
                            col_eff = '0;
                            len_eff = '0;
                        end

                        if (run_ok)
                        begin
                            in_run_next = 1'b1;
                            row_next    = row_eff;
                            col_next    = col_eff;
                            len_next    = len_eff;
                            if (len_eff >= head_area)
                            begin
                                err_next = ERR_MISMATCH;
                            end
                            else
                            begin
                                tok_valid = 1'b1;
                                tp        = cur_reg;
                                hp        = cur_reg + POS_W'(row_eff);
                                wp        = cur_reg + POS_W'(col_eff);
                                len_next  = len_eff + (2*SIDE_W)'(1);
                                // raster walk: wrap the column, step the row
                                if (({1'b0, col_eff} + (SIDE_W+1)'(1))
                                    >= {1'b0, head_cols})
                                begin
                                    col_next = '0;
                                    row_next = row_eff + SIDE_W'(1);
                                end
                                else
                                begin
                                    col_next = col_eff + SIDE_W'(1);
                                end
                            end
                        end
                    end
                end
                KIND_FINISH:
                begin
                    if (err_reg == ERR_NONE)
                    begin
                        in_run_next = 1'b0;
                        if (close_fail)
                        begin
                            err_next = ERR_MISMATCH;
                        end
                        else
                        begin
                            cur_next = closed_cur;
                            idx_next = closed_idx;
                            row_next = '0;
                            col_next = '0;
                            len_next = '0;
                            if (closed_idx != loaded_reg)
                            begin
                                err_next = ERR_UNUSED;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        out_valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            loaded_reg    <= '0;
            idx_reg       <= '0;
            in_run_reg    <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            len_reg       <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            loaded_reg    <= loaded_next;
            idx_reg       <= idx_next;
            in_run_reg    <= in_run_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            len_reg       <= len_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            fwd_hit_reg   <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wr_data;
        if (fire)
        begin
            // an erroring item carries no positions
            posv_reg <= tok_valid && (err_next == ERR_NONE);
            tp_reg   <= (err_next == ERR_NONE) ? tp : '0;
            hp_reg   <= (err_next == ERR_NONE) ? hp : '0;
            wp_reg   <= (err_next == ERR_NONE) ? wp : '0;
            eo_reg   <= err_next;
            np_reg   <= cur_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign position_valid  = posv_reg;
    assign time_position   = POS_FIELD_BITS'(tp_reg);
    assign height_position = POS_FIELD_BITS'(hp_reg);
    assign width_position  = POS_FIELD_BITS'(wp_reg);
    assign error_code      = eo_reg;
    assign next_position   = POS_FIELD_BITS'(np_reg);

endmodule

`default_nettype wire

// ===== src/multimodal_rope_position_builder.sv =====
// Three-axis (time, height, width) position builder for a prompt of mixed
// text and image tokens.
// Input channel in_valid/in_ready carries one beat per item: begin prompt,
// add image grid, token (text or image) or finish. Output channel
// out_valid/out_ready returns exactly one beat per input beat, in order.
// Throughput: one beat per cycle, sustained while out_ready stays high. The rate is set by the state
// update of the execute stage, which does one add and one compare per token;
// grid sizes sit in a small RAM whose registered read always tracks the next
// grid to use, with forwarding of a write to that same entry.
// A two-deep queue separates the decode stage from the execute stage, and a
// single output register holds the result; in_ready stays high while the
// queue has room, so a stalled receiver only blocks input once the queue fills.
// Reset clears the position, grid count, run state and the sticky error; grid
// RAM contents are left as they are and only read once written.
// Once an error is raised, every beat other than begin returns no positions
// and carries the error code until the next begin.

`default_nettype none

module multimodal_rope_position_builder
    import mrpb_pkg::*;
#(
    parameter int MAX_GRIDS      = 16,
    parameter int GRID_SIDE_BITS = 10,
    parameter int POSITION_BITS  = 31
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 op,
    input  wire logic [POS_FIELD_BITS-1:0]  start_position,
    input  wire logic [GRID_FIELD_BITS-1:0] grid_rows,
    input  wire logic [GRID_FIELD_BITS-1:0] grid_cols,
    input  wire logic                       image_token,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            position_valid,
    output logic      [POS_FIELD_BITS-1:0]  time_position,
    output logic      [POS_FIELD_BITS-1:0]  height_position,
    output logic      [POS_FIELD_BITS-1:0]  width_position,
    output logic      [2:0]                 error_code,
    output logic      [POS_FIELD_BITS-1:0]  next_position
);

    // grid side bits actually seen on the 10-bit grid fields
    localparam int SIDE_W  = (GRID_SIDE_BITS < GRID_FIELD_BITS) ?
                             GRID_SIDE_BITS : GRID_FIELD_BITS;
    localparam int POS_W   = POSITION_BITS;
    // one grid entry: area, larger side, columns
    localparam int ENTRY_W = 4 * SIDE_W;
    localparam int ADDR_W  = (MAX_GRIDS > 1) ? $clog2(MAX_GRIDS) : 1;

    logic                q_valid;
    logic                q_pop;
    item_ctrl_t          q_ctrl;
    logic [POS_W-1:0]    q_start;
    logic [ENTRY_W-1:0]  q_entry;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    // decode: masks grid sides, precomputes area and larger side
    mrpb_front #(
        .SIDE_W (SIDE_W),
        .POS_W  (POS_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .start_position (start_position),
        .grid_rows      (grid_rows),
        .grid_cols      (grid_cols),
        .image_token    (image_token),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_ctrl         (q_ctrl),
        .q_start        (q_start),
        .q_entry        (q_entry)
    );

    // grid table
    mrpb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_GRIDS)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // execute: position counter, run walk, sticky errors, output register
    mrpb_back #(
        .MAX_GRIDS (MAX_GRIDS),
        .SIDE_W    (SIDE_W),
        .POS_W     (POS_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_ctrl          (q_ctrl),
        .q_start         (q_start),
        .q_entry         (q_entry),
        .ram_wr_en       (ram_wr_en),
        .ram_wr_addr     (ram_wr_addr),
        .ram_wr_data     (ram_wr_data),
        .ram_rd_addr     (ram_rd_addr),
        .ram_rd_data     (ram_rd_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .position_valid  (position_valid),
        .time_position   (time_position),
        .height_position (height_position),
        .width_position  (width_position),
        .error_code      (error_code),
        .next_position   (next_position)
    );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

// Testbench for the three-axis position builder.
// A sender task drives one beat per call, predicts the result beat as the beat is
// accepted and queues it. A checker compares every result beat with the oldest
// prediction. Directed tests come first, then random prompts under four idling
// phases, with one long receiver hold-off to push the block into back-pressure.
module testbench;

    import mrpb_pkg::*;

    localparam int     GRID_SLOTS = 16;             // depth of the grid store in the block
    localparam longint POS_LIMIT  = 64'h7FFF_FFFF;  // largest legal position

    // one result beat as the block should produce it
    typedef struct {
        logic                      has_pos;
        logic [POS_FIELD_BITS-1:0] t_pos;
        logic [POS_FIELD_BITS-1:0] h_pos;
        logic [POS_FIELD_BITS-1:0] w_pos;
        logic [2:0]                err;
        logic [POS_FIELD_BITS-1:0] nxt_pos;
    } position_beat_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 op;
    logic [POS_FIELD_BITS-1:0]  start_position;
    logic [GRID_FIELD_BITS-1:0] grid_rows;
    logic [GRID_FIELD_BITS-1:0] grid_cols;
    logic                       image_token;
    logic                       out_valid;
    logic                       out_ready;
    logic                       position_valid;
    logic [POS_FIELD_BITS-1:0]  time_position;
    logic [POS_FIELD_BITS-1:0]  height_position;
    logic [POS_FIELD_BITS-1:0]  width_position;
    logic [2:0]                 error_code;
    logic [POS_FIELD_BITS-1:0]  next_position;

    // predicted result beats, oldest first
    position_beat_t pending_positions[$];

    int error_count;
    int items_sent;
    int sender_idle_pct;
    int receiver_stall_pct;
    int holdoff_left;       // set by a test, counted down by the receiver process

    // predictor state: mirrors the block's prompt state
    logic [POS_FIELD_BITS-1:0] pos_now;
    int                        grid_rows_tab[GRID_SLOTS];
    int                        grid_cols_tab[GRID_SLOTS];
    int                        grids_held;
    int                        grid_next;
    bit                        run_open;
    int                        run_r;
    int                        run_c;
    int                        run_count;
    logic [2:0]                err_latched;

    multimodal_rope_position_builder DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .start_position  (start_position),
        .grid_rows       (grid_rows),
        .grid_cols       (grid_cols),
        .image_token     (image_token),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .position_valid  (position_valid),
        .time_position   (time_position),
        .height_position (height_position),
        .width_position  (width_position),
        .error_code      (error_code),
        .next_position   (next_position)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop, well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // position advance of a finished run over grid g: the larger side
    function automatic int grid_advance(input int g);
        return (grid_rows_tab[g] > grid_cols_tab[g]) ? grid_rows_tab[g] : grid_cols_tab[g];
    endfunction

    // closes an open image run; returns 0 when the run length was wrong
    function automatic bit close_image_run();
        int g;
        if (!run_open)
            return 1'b1;
        g        = grid_next % GRID_SLOTS;
        run_open = 1'b0;
        if (run_count != grid_rows_tab[g] * grid_cols_tab[g])
        begin
            err_latched = ERR_MISMATCH;
            return 1'b0;
        end
        // overflow was ruled out when the run opened
        pos_now   = pos_now + POS_FIELD_BITS'(grid_advance(g));
        grid_next = grid_next + 1;
        run_r     = 0;
        run_c     = 0;
        run_count = 0;
        return 1'b1;
    endfunction

    // works out the result beat of one accepted input beat and queues it
    task automatic predict_positions(input logic [1:0] code,
                                     input logic [POS_FIELD_BITS-1:0] start,
                                     input logic [GRID_FIELD_BITS-1:0] rows_in,
                                     input logic [GRID_FIELD_BITS-1:0] cols_in,
                                     input logic img);
        position_beat_t beat;
        int             g;
        beat = '{has_pos: 1'b0, t_pos: '0, h_pos: '0, w_pos: '0, err: ERR_NONE, nxt_pos: '0};
        if (code == OP_BEGIN)
        begin
            // a 31-bit start can never exceed the position range
            pos_now     = start;
            grids_held  = 0;
            grid_next   = 0;
            run_open    = 1'b0;
            run_r       = 0;
            run_c       = 0;
            run_count   = 0;
            err_latched = ERR_NONE;
        end
        else if (err_latched == ERR_NONE)
        begin
            case (code)
                OP_GRID:
                begin
                    if (rows_in == 0 || cols_in == 0)
                        err_latched = ERR_EMPTY;
                    else if (grids_held >= GRID_SLOTS)
                        err_latched = ERR_OVERFLOW;
                    else
                    begin
                        grid_rows_tab[grids_held] = rows_in;
                        grid_cols_tab[grids_held] = cols_in;
                        grids_held = grids_held + 1;
                    end
                end
                OP_TOKEN:
                begin
                    if (!img)
                    begin
                        if (close_image_run())
                        begin
                            if (longint'(pos_now) + 1 > POS_LIMIT)
                                err_latched = ERR_OVERFLOW;
                            else
                            begin
                                beat.has_pos = 1'b1;
                                beat.t_pos   = pos_now;
                                beat.h_pos   = pos_now;
                                beat.w_pos   = pos_now;
                                pos_now      = pos_now + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (!run_open)
                        begin
                            if (grid_next >= grids_held)
                                err_latched = ERR_NO_GRID;
                            else if (longint'(pos_now) + grid_advance(grid_next % GRID_SLOTS)
                                     > POS_LIMIT)
                                err_latched = ERR_OVERFLOW;
                            else
                            begin
                                run_open  = 1'b1;
                                run_r     = 0;
                                run_c     = 0;
                                run_count = 0;
                            end
                        end
                        if (err_latched == ERR_NONE)
                        begin
                            g = grid_next % GRID_SLOTS;
                            if (run_count >= grid_rows_tab[g] * grid_cols_tab[g])
                                err_latched = ERR_MISMATCH;
                            else
                            begin
                                // raster walk of the grid
                                beat.has_pos = 1'b1;
                                beat.t_pos   = pos_now;
                                beat.h_pos   = pos_now + POS_FIELD_BITS'(run_r);
                                beat.w_pos   = pos_now + POS_FIELD_BITS'(run_c);
                                run_count    = run_count + 1;
                                if (run_c + 1 >= grid_cols_tab[g])
                                begin
                                    run_c = 0;
                                    run_r = run_r + 1;
                                end
                                else
                                    run_c = run_c + 1;
                            end
                        end
                    end
                end
                default:
                begin
                    // finish: close the run, then every loaded grid must be used
                    if (close_image_run())
                    begin
                        if (grid_next != grids_held)
                            err_latched = ERR_UNUSED;
                    end
                end
            endcase
        end
        if (err_latched != ERR_NONE)
        begin
            beat.has_pos = 1'b0;
            beat.t_pos   = '0;
            beat.h_pos   = '0;
            beat.w_pos   = '0;
        end
        beat.err     = err_latched;
        beat.nxt_pos = pos_now;
        pending_positions.push_back(beat);
    endtask

    // ------------------------------------------------------------------
    // Sender: inputs change on the falling edge, acceptance seen on the rising edge.
    // Valid is left high after a beat; the next call either replaces the payload or
    // drops valid while it idles first.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] code,
                             input logic [POS_FIELD_BITS-1:0] start,
                             input logic [GRID_FIELD_BITS-1:0] rows_in,
                             input logic [GRID_FIELD_BITS-1:0] cols_in,
                             input logic img);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        op             = code;
        start_position = start;
        grid_rows      = rows_in;
        grid_cols      = cols_in;
        image_token    = img;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent = items_sent + 1;
        predict_positions(code, start, rows_in, cols_in, img);
    endtask

    // unused fields carry random junk so the block must ignore them
    task automatic send_begin(input logic [POS_FIELD_BITS-1:0] start);
        send_beat(OP_BEGIN, start, GRID_FIELD_BITS'($urandom), GRID_FIELD_BITS'($urandom),
                  1'($urandom));
    endtask

    task automatic send_grid(input int rows_in, input int cols_in);
        send_beat(OP_GRID, POS_FIELD_BITS'($urandom), GRID_FIELD_BITS'(rows_in),
                  GRID_FIELD_BITS'(cols_in), 1'($urandom));
    endtask

    task automatic send_text();
        send_beat(OP_TOKEN, POS_FIELD_BITS'($urandom), GRID_FIELD_BITS'($urandom),
                  GRID_FIELD_BITS'($urandom), 1'b0);
    endtask

    task automatic send_image();
        send_beat(OP_TOKEN, POS_FIELD_BITS'($urandom), GRID_FIELD_BITS'($urandom),
                  GRID_FIELD_BITS'($urandom), 1'b1);
    endtask

    task automatic send_finish();
        send_beat(OP_FINISH, POS_FIELD_BITS'($urandom), GRID_FIELD_BITS'($urandom),
                  GRID_FIELD_BITS'($urandom), 1'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready changes on the falling edge. A requested hold-off keeps it
    // low until holdoff_left has counted down to zero, whatever the stall rate.
    // ------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_left > 0)
            begin
                out_ready    = 1'b0;
                holdoff_left = holdoff_left - 1;
            end
            else
                out_ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count = error_count + 1;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        position_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_positions.size() == 0)
            begin
                $error("result beat with no prediction waiting");
                error_count = error_count + 1;
            end
            else
            begin
                want = pending_positions.pop_front();
                check_field("position_valid", want.has_pos, position_valid);
                check_field("time_position", want.t_pos, time_position);
                check_field("height_position", want.h_pos, height_position);
                check_field("width_position", want.w_pos, width_position);
                check_field("error_code", want.err, error_code);
                check_field("next_position", want.nxt_pos, next_position);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // well-formed prompt: text, a run with a grid added mid-run, a 1x1 run
    // closed by finish, and a text token after finish
    task automatic test_text_and_image_runs();
        send_begin(5);
        send_grid(2, 2);
        send_text();
        send_image();
        send_image();
        send_grid(1, 1);
        send_image();
        send_image();
        send_text();
        send_image();
        send_finish();
        send_text();
    endtask

    // zero-sided grids, sticky behaviour, image run with no grid loaded
    task automatic test_grid_faults();
        send_begin(0);
        send_grid(0, 1023);
        send_text();
        send_begin(0);
        send_grid(1023, 0);
        send_begin(0);
        send_image();
    endtask

    // run longer than its grid, and a full-size grid cut short by text
    task automatic test_run_length_faults();
        send_begin(7);
        send_grid(1, 1);
        send_image();
        send_image();
        send_begin(9);
        send_grid(1023, 1023);
        send_image();
        send_text();
    endtask

    task automatic test_unused_grids();
        send_begin(3);
        send_grid(1, 2);
        send_finish();
    endtask

    // text step past the top, then a run that cannot fit at the top
    task automatic test_position_overflow();
        send_begin(31'h7FFF_FFFE);
        send_text();
        send_text();
        send_begin(31'h7FFF_FFFF);
        send_grid(1, 1);
        send_image();
    endtask

    // one grid more than the store holds
    task automatic test_grid_table_full();
        send_begin(0);
        repeat (GRID_SLOTS + 1)
            send_grid($urandom_range(1, 4), $urandom_range(1, 4));
    endtask

    // tall and wide runs so row and column counters go through every bit
    task automatic test_long_runs();
        send_begin(31'($urandom) & 31'h3FFF_FFFF);
        send_grid(513, 1);
        send_grid(1, 514);
        repeat (513)
            send_image();
        send_text();
        repeat (514)
            send_image();
        send_finish();
    endtask

    // receiver holds off while the sender keeps offering; input must stall
    task automatic test_input_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        holdoff_left       = 300;
        send_begin(100);
        send_grid(3, 3);
        send_grid(2, 5);
        repeat (3)
            send_text();
        repeat (9)
            send_image();
        send_text();
        repeat (10)
            send_image();
        send_finish();
    endtask

    // one random prompt: mostly well-formed, some cut runs, odd lengths and junk
    task automatic random_prompt();
        int rows_plan[GRID_SLOTS + 1];
        int cols_plan[GRID_SLOTS + 1];
        bit cut_plan[GRID_SLOTS + 1];
        int n_grids;
        int loaded;
        int len;
        if ($urandom_range(9) == 0)
            send_begin(31'h7FFF_FFFF - 31'($urandom_range(0, 64)));
        else
            send_begin(31'($urandom));
        n_grids = ($urandom_range(19) == 0) ? $urandom_range(5, GRID_SLOTS + 1)
                                            : $urandom_range(0, 3);
        for (int i = 0; i < n_grids; i++)
        begin
            // rare full-range grids get a run of one to six images: far too long otherwise
            cut_plan[i] = ($urandom_range(29) == 0);
            rows_plan[i] = cut_plan[i] ? $urandom_range(0, 1023) : $urandom_range(1, 4);
            cols_plan[i] = cut_plan[i] ? $urandom_range(0, 1023) : $urandom_range(1, 4);
        end
        loaded = $urandom_range(0, n_grids);
        for (int i = 0; i < loaded; i++)
            send_grid(rows_plan[i], cols_plan[i]);
        for (int i = 0; i < n_grids; i++)
        begin
            repeat ($urandom_range(0, 3))
                send_text();
            while (loaded <= i)
            begin
                send_grid(rows_plan[loaded], cols_plan[loaded]);
                loaded = loaded + 1;
            end
            len = rows_plan[i] * cols_plan[i];
            if (cut_plan[i])
                len = $urandom_range(1, 6);
            else if ($urandom_range(19) == 0)
                len = $urandom_range(1) ? len + 1 : len - 1;
            for (int k = 0; k < len; k++)
            begin
                // grids may arrive in the middle of a run
                if (loaded < n_grids && $urandom_range(9) == 0)
                begin
                    send_grid(rows_plan[loaded], cols_plan[loaded]);
                    loaded = loaded + 1;
                end
                send_image();
            end
            if ($urandom_range(24) == 0)
                send_beat(2'($urandom), POS_FIELD_BITS'($urandom),
                          GRID_FIELD_BITS'($urandom), GRID_FIELD_BITS'($urandom),
                          1'($urandom));
        end
        repeat ($urandom_range(0, 2))
            send_text();
        if ($urandom_range(9) != 0)
            send_finish();
    endtask

    // four idling phases: none, sender gaps, receiver stalls, both
    task automatic test_random_prompts();
        int idle_set[4];
        int stall_set[4];
        int target;
        idle_set  = '{0, 59, 0, 17};
        stall_set = '{0, 0, 59, 17};
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct    = idle_set[p];
            receiver_stall_pct = stall_set[p];
            target             = items_sent + 180;
            while (items_sent < target)
                random_prompt();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        error_count        = 0;
        items_sent         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        holdoff_left       = 0;
        pos_now            = '0;
        grids_held         = 0;
        grid_next          = 0;
        run_open           = 1'b0;
        run_r              = 0;
        run_c              = 0;
        run_count          = 0;
        err_latched        = ERR_NONE;
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        op                 = OP_BEGIN;
        start_position     = '0;
        grid_rows          = '0;
        grid_cols          = '0;
        image_token        = 1'b0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_text_and_image_runs();
        test_grid_faults();
        test_run_length_faults();
        test_unused_grids();
        test_position_overflow();
        test_grid_table_full();
        test_long_runs();
        test_input_backpressure();
        test_random_prompts();

        // let everything drain, then keep the checker running to catch anything unpredicted
        @(negedge clk);
        in_valid           = 1'b0;
        receiver_stall_pct = 0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (pending_positions.size() != 0)
        begin
            $error("%0d predicted result beats never arrived", pending_positions.size());
            error_count = error_count + 1;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
